// ===== rtl/gclr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclr_pkg
// Shared types for the GCD / LCM ratio reducer: sequencer states and the
// control and status groups between the sequencer and the divider.
// ----------------------------------------------------------------------------
package gclr_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODX,
        ST_MODY,
        ST_DIVP,
        ST_DIVQ,
        ST_DONE
    } gclr_state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_stat_t;

endpackage

// ===== rtl/gclr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclr_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gclr_div
    import gclr_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  div_ctrl_t    ctrl,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] den,
    output div_stat_t    stat,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;

    // shift in next dividend bit, then try subtracting
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);
    assign quotient      = quo_reg;
    assign remainder     = rem_reg;

endmodule

// ===== rtl/gcd_lcm_ratio_reducer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_lcm_ratio_reducer_top
// Euclid GCD with LCM and reduced ratio, built on one shared serial divider.
// ----------------------------------------------------------------------------
//
//  channel   handshake                   payload
//  -------   -------------------------   --------------------------------------
//  item      item_valid / item_stall     first_value, second_value
//  result    result_valid / result_stall divisor, multiple, multiple_too_big,
//                                        reduced_first, reduced_second,
//                                        both_zero
//
//  Each item runs Euclid remainder passes on the shared divider until a
//  remainder is zero, then two quotient passes for p / g and q / g.
//  An operand of zero skips the divider and goes straight to the done state.
//  item_stall is high from acceptance until the result is loaded into the
//  output register; a result held by result_stall blocks only the finish
//  of the following item. Reset clears the sequencer and result valid.
//
module gcd_lcm_ratio_reducer_top
    import gclr_pkg::*;
#(
    parameter int OPERAND_BITS = 31
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [OPERAND_BITS-1:0]   first_value,
    input  logic [OPERAND_BITS-1:0]   second_value,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic [OPERAND_BITS-1:0]   divisor,
    output logic [2*OPERAND_BITS-1:0] multiple,
    output logic                      multiple_too_big,
    output logic [OPERAND_BITS-1:0]   reduced_first,
    output logic [OPERAND_BITS-1:0]   reduced_second,
    output logic                      both_zero
);

    localparam int W  = OPERAND_BITS;
    localparam int MW = 2 * OPERAND_BITS;

    // sequencer state
    gclr_state_t state_reg, state_next;
    logic        start_reg, start_next;
    logic        result_valid_reg, result_valid_next;

    // working operands
    logic [W-1:0] p_reg, p_next;        // original first operand
    logic [W-1:0] q_reg, q_next;        // original second operand
    logic [W-1:0] x_reg, x_next;        // Euclid pair
    logic [W-1:0] y_reg, y_next;
    logic [W-1:0] g_reg, g_next;        // gcd
    logic [W-1:0] rp_reg, rp_next;      // p / g
    logic [W-1:0] rq_reg, rq_next;      // q / g
    logic         trivial_reg, trivial_next;  // an operand was zero
    logic         bz_reg, bz_next;

    // output register
    logic [W-1:0]  divisor_reg;
    logic [MW-1:0] multiple_reg;
    logic          too_big_reg;
    logic [W-1:0]  reduced_first_reg;
    logic [W-1:0]  reduced_second_reg;
    logic          both_zero_reg;
    logic          out_load;

    // divider hookup
    div_ctrl_t    div_ctrl;
    div_stat_t    div_stat;
    logic [W-1:0] div_dividend;
    logic [W-1:0] div_den;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    logic [MW-1:0] product;
    logic          item_accept;

    assign item_stall  = (state_reg != ST_IDLE);
    assign item_accept = item_valid && !item_stall;

    assign div_ctrl.start = start_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_MODX:
            begin
                div_dividend = x_reg;
                div_den      = y_reg;
            end
            ST_MODY:
            begin
                div_dividend = y_reg;
                div_den      = x_reg;
            end
            ST_DIVP:
            begin
                div_dividend = p_reg;
                div_den      = g_reg;
            end
            ST_DIVQ:
            begin
                div_dividend = q_reg;
                div_den      = g_reg;
            end
            default:
            begin
                div_dividend = x_reg;
                div_den      = y_reg;
            end
        endcase
    end

    gclr_div #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .den       (div_den),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // lcm = (p / g) * q; zero when an operand was zero
    assign product = trivial_reg ? '0 : (MW'(rp_reg) * MW'(q_reg));

    always_comb
    begin
        state_next        = state_reg;
        start_next        = 1'b0;
        result_valid_next = result_valid_reg;
        p_next            = p_reg;
        q_next            = q_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        g_next            = g_reg;
        rp_next           = rp_reg;
        rq_next           = rq_reg;
        trivial_next      = trivial_reg;
        bz_next           = bz_reg;
        out_load          = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    p_next       = first_value;
                    q_next       = second_value;
                    x_next       = first_value;
                    y_next       = second_value;
                    trivial_next = 1'b1;
                    bz_next      = 1'b0;
                    if (first_value == '0 && second_value == '0)
                    begin
                        g_next     = '0;
                        rp_next    = '0;
                        rq_next    = '0;
                        bz_next    = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (first_value == '0)
                    begin
                        g_next     = second_value;
                        rp_next    = '0;
                        rq_next    = W'(1);
                        state_next = ST_DONE;
                    end
                    else if (second_value == '0)
                    begin
                        g_next     = first_value;
                        rp_next    = W'(1);
                        rq_next    = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        trivial_next = 1'b0;
                        start_next   = 1'b1;
                        state_next   = ST_MODX;
                    end
                end
            end
            ST_MODX:
            begin
                if (div_stat.done)
                begin
                    start_next = 1'b1;
                    if (div_stat.rem_zero)
                    begin
                        g_next     = y_reg;
                        state_next = ST_DIVP;
                    end
                    else
                    begin
                        x_next     = div_rem;
                        state_next = ST_MODY;
                    end
                end
            end
            ST_MODY:
            begin
                if (div_stat.done)
                begin
                    start_next = 1'b1;
                    if (div_stat.rem_zero)
                    begin
                        g_next     = x_reg;
                        state_next = ST_DIVP;
                    end
                    else
                    begin
                        y_next     = div_rem;
                        state_next = ST_MODX;
                    end
                end
            end
            ST_DIVP:
            begin
                if (div_stat.done)
                begin
                    rp_next    = div_quo;
                    start_next = 1'b1;
                    state_next = ST_DIVQ;
                end
            end
            ST_DIVQ:
            begin
                if (div_stat.done)
                begin
                    rq_next    = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to be free
                if (!result_valid_reg || !result_stall)
                begin
                    out_load          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            start_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            start_reg        <= start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        q_reg       <= q_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        g_reg       <= g_next;
        rp_reg      <= rp_next;
        rq_reg      <= rq_next;
        trivial_reg <= trivial_next;
        bz_reg      <= bz_next;
        if (out_load)
        begin
            divisor_reg        <= g_reg;
            multiple_reg       <= product;
            too_big_reg        <= |product[MW-1:W];
            reduced_first_reg  <= rp_reg;
            reduced_second_reg <= rq_reg;
            both_zero_reg      <= bz_reg;
        end
    end

    assign result_valid     = result_valid_reg;
    assign divisor          = divisor_reg;
    assign multiple         = multiple_reg;
    assign multiple_too_big = too_big_reg;
    assign reduced_first    = reduced_first_reg;
    assign reduced_second   = reduced_second_reg;
    assign both_zero        = both_zero_reg;

endmodule
